FILE: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: round-robin scheduler shared definitions
// item layouts, queue entry layout, event codes and default sizes
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int ID_W          = 22;
    localparam int CNT_W         = 16;
    localparam int EV_W          = 3;
    localparam int MAX_PROCS_DEF = 16;

    localparam logic [CNT_W-1:0] SLICE_RESET = 16'd225;

    // request kinds
    localparam logic REQ_ADMIT = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // result events
    localparam logic [EV_W-1:0] EV_ADMITTED  = 3'd0;
    localparam logic [EV_W-1:0] EV_REJECTED  = 3'd1;
    localparam logic [EV_W-1:0] EV_ALL_IDLE  = 3'd2;
    localparam logic [EV_W-1:0] EV_RAN       = 3'd3;
    localparam logic [EV_W-1:0] EV_FINISHED  = 3'd4;
    localparam logic [EV_W-1:0] EV_PREEMPTED = 3'd5;
    localparam logic [EV_W-1:0] EV_ONLY_WAIT = 3'd6;

    typedef struct packed {
        logic             req_type;
        logic [ID_W-1:0]  proc_id;
        logic [CNT_W-1:0] cpu_burst;
        logic [CNT_W-1:0] io_burst;
    } t_req;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic [ID_W-1:0]  run_id;
        logic [CNT_W-1:0] cpu_left;
        logic             woke;
        logic [ID_W-1:0]  woke_id;
    } t_res;

    // queue entry: aux is the slice in the run queue, the i/o count in the wait queue
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cpu;
        logic [CNT_W-1:0] aux;
    } t_entry;

endpackage

FILE: rtl/round_robin_scheduler_with_io_wait.sv
// ----------------------------------------------------------------------------
// round_robin_scheduler_with_io_wait: round-robin tick scheduler
// run queue and i/o wait queue in rams, ticks walked by a small sequencer
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_req)
//  out     | output    | o_out_valid / i_out_ready  | o_out_item (t_res)
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_wdata (slice)
//
//  an admit goes straight to the output; a tick walks the wait queue, if it is not
//  empty, one entry per cycle through the wait ram read/write ports and the shared
//  saturating decrementer, tries to wake its head, reads the run head, decrements
//  cpu left and slice and decides, or stops after the run head read if none is left
//  one item at a time: o_in_ready is high only while the sequencer is idle
//  the result is held in a register until taken; a stalled output holds the block
//  synchronous active-low reset empties both queues and loads the slice with 225;
//  ram contents are not cleared, empty slots are never read
//
module round_robin_scheduler_with_io_wait
    import rrs_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_res             o_out_item,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int IW  = $clog2(MAX_PROCS);
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int CW1 = CW + 1;
    localparam int EW  = $bits(t_entry);

    localparam logic [CW-1:0]  L_MAX_C  = CW'(MAX_PROCS);
    localparam logic [CW:0]    L_MAX_S  = CW1'(MAX_PROCS);
    localparam logic [CW-1:0]  L_ONE_C  = CW'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_WAKE   = 3'd2;
    localparam logic [2:0] S_RUN_RD = 3'd3;
    localparam logic [2:0] S_CPU    = 3'd4;
    localparam logic [2:0] S_SLICE  = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // ring slot: (head + offset) mod depth, sum stays below twice the depth
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] head,
                                             input logic [CW-1:0] offset);
        logic [CW:0] sum;
        sum = CW1'(head) + CW1'(offset);
        if (sum >= L_MAX_S) begin
            sum = sum - L_MAX_S;
        end
        return sum[IW-1:0];
    endfunction

    // control state
    logic [2:0]       r_state,      n_state;
    logic [IW-1:0]    r_run_head,   n_run_head;
    logic [CW-1:0]    r_run_count,  n_run_count;
    logic [IW-1:0]    r_wait_head,  n_wait_head;
    logic [CW-1:0]    r_wait_count, n_wait_count;
    logic [CNT_W-1:0] r_time_slice;
    logic [CW-1:0]    r_idx,        n_idx;
    logic             r_pend,       n_pend;

    // working payload
    logic [IW-1:0]    r_waddr, n_waddr;
    logic [ID_W-1:0]  r_hid,   n_hid;
    logic [CNT_W-1:0] r_hcpu,  n_hcpu;
    logic [CNT_W-1:0] r_hio,   n_hio;
    logic             r_woke,  n_woke;
    logic [ID_W-1:0]  r_wid,   n_wid;
    logic [ID_W-1:0]  r_rid,   n_rid;
    logic [CNT_W-1:0] r_cpu,   n_cpu;
    logic [CNT_W-1:0] r_slice, n_slice;
    logic [CNT_W-1:0] r_io,    n_io;
    t_res             r_out,   n_out;

    // ram ports
    logic          run_we,  wait_we;
    logic [IW-1:0] run_waddr, wait_waddr, run_raddr, wait_raddr;
    t_entry        run_wdata, wait_wdata, run_rd, wait_rd;

    // shared saturating decrementer
    logic [CNT_W-1:0] dec_in, dec_out;

    rrs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (run_waddr),
        .i_wdata (run_wdata),
        .i_raddr (run_raddr),
        .o_rdata (run_rd)
    );

    rrs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wait_we),
        .i_waddr (wait_waddr),
        .i_wdata (wait_wdata),
        .i_raddr (wait_raddr),
        .o_rdata (wait_rd)
    );

    // run queue is only ever read at its head; the walk reads the wait queue in order
    assign run_raddr  = r_run_head;
    assign wait_raddr = f_slot(r_wait_head, r_idx);

    // operand select for the decrementer: i/o count, cpu left or slice
    always_comb begin
        case (r_state)
            S_WALK:  dec_in = wait_rd.aux;
            S_CPU:   dec_in = run_rd.cpu;
            default: dec_in = r_slice;
        endcase
        dec_out = (dec_in == '0) ? '0 : dec_in - CNT_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_run_head   = r_run_head;
        n_run_count  = r_run_count;
        n_wait_head  = r_wait_head;
        n_wait_count = r_wait_count;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_waddr      = r_waddr;
        n_hid        = r_hid;
        n_hcpu       = r_hcpu;
        n_hio        = r_hio;
        n_woke       = r_woke;
        n_wid        = r_wid;
        n_rid        = r_rid;
        n_cpu        = r_cpu;
        n_slice      = r_slice;
        n_io         = r_io;
        n_out        = r_out;
        run_we       = 1'b0;
        run_waddr    = f_slot(r_run_head, r_run_count);
        run_wdata    = '0;
        wait_we      = 1'b0;
        wait_waddr   = r_waddr;
        wait_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_io   = i_in_item.io_burst;
                    n_woke = 1'b0;
                    n_wid  = '0;
                    if (i_in_item.req_type == REQ_ADMIT) begin
                        n_out.run_id   = i_in_item.proc_id;
                        n_out.cpu_left = i_in_item.cpu_burst;
                        n_out.woke     = 1'b0;
                        n_out.woke_id  = '0;
                        if (r_run_count == L_MAX_C) begin
                            n_out.event_res = EV_REJECTED;
                        end else begin
                            // append at the run tail with a full slice
                            run_we          = 1'b1;
                            run_wdata.id    = i_in_item.proc_id;
                            run_wdata.cpu   = i_in_item.cpu_burst;
                            run_wdata.aux   = r_time_slice;
                            n_run_count     = r_run_count + L_ONE_C;
                            n_out.event_res = EV_ADMITTED;
                        end
                        n_state = S_OUT;
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = (r_wait_count != '0) ? S_WALK : S_RUN_RD;
                    end
                end
            end

            S_WALK: begin
                // write back the entry read last cycle with its i/o count decremented
                if (r_pend) begin
                    wait_we        = 1'b1;
                    wait_waddr     = r_waddr;
                    wait_wdata.id  = wait_rd.id;
                    wait_wdata.cpu = wait_rd.cpu;
                    wait_wdata.aux = dec_out;
                    if (r_waddr == r_wait_head) begin
                        n_hid  = wait_rd.id;
                        n_hcpu = wait_rd.cpu;
                        n_hio  = dec_out;
                    end
                end
                // issue the next read, one entry per cycle
                if (r_idx != r_wait_count) begin
                    n_pend  = 1'b1;
                    n_waddr = wait_raddr;
                    n_idx   = r_idx + L_ONE_C;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_WAKE;
                    end
                end
            end

            S_WAKE: begin
                // head of the wait queue returns once its i/o is done and there is room
                if (r_hio == '0 && r_run_count != L_MAX_C) begin
                    run_we        = 1'b1;
                    run_wdata.id  = r_hid;
                    run_wdata.cpu = r_hcpu;
                    run_wdata.aux = r_time_slice;
                    n_run_count   = r_run_count + L_ONE_C;
                    n_wait_head   = f_slot(r_wait_head, L_ONE_C);
                    n_wait_count  = r_wait_count - L_ONE_C;
                    n_woke        = 1'b1;
                    n_wid         = r_hid;
                end
                n_state = S_RUN_RD;
            end

            S_RUN_RD: begin
                // run head read is in flight here
                if (r_run_count == '0) begin
                    n_out.event_res = (r_wait_count != '0) ? EV_ONLY_WAIT : EV_ALL_IDLE;
                    n_out.run_id    = '0;
                    n_out.cpu_left  = '0;
                    n_out.woke      = r_woke;
                    n_out.woke_id   = r_wid;
                    n_state         = S_OUT;
                end else begin
                    n_state = S_CPU;
                end
            end

            S_CPU: begin
                n_rid   = run_rd.id;
                n_cpu   = dec_out;
                n_slice = run_rd.aux;
                n_state = S_SLICE;
            end

            S_SLICE: begin
                n_slice = dec_out;
                n_state = S_DECIDE;
            end

            S_DECIDE: begin
                n_out.run_id   = r_rid;
                n_out.cpu_left = r_cpu;
                n_out.woke     = r_woke;
                n_out.woke_id  = r_wid;
                if (r_cpu == '0) begin
                    n_run_head      = f_slot(r_run_head, L_ONE_C);
                    n_run_count     = r_run_count - L_ONE_C;
                    n_out.event_res = EV_FINISHED;
                end else if (r_slice == '0) begin
                    n_run_head = f_slot(r_run_head, L_ONE_C);
                    if (r_wait_count != L_MAX_C) begin
                        // preempt into the wait queue tail
                        n_run_count     = r_run_count - L_ONE_C;
                        wait_we         = 1'b1;
                        wait_waddr      = f_slot(r_wait_head, r_wait_count);
                        wait_wdata.id   = r_rid;
                        wait_wdata.cpu  = r_cpu;
                        wait_wdata.aux  = r_io;
                        n_wait_count    = r_wait_count + L_ONE_C;
                        n_out.event_res = EV_PREEMPTED;
                    end else begin
                        // wait queue full: rotate to the run tail with a new slice
                        run_we          = 1'b1;
                        run_waddr       = f_slot(r_run_head, r_run_count);
                        run_wdata.id    = r_rid;
                        run_wdata.cpu   = r_cpu;
                        run_wdata.aux   = r_time_slice;
                        n_out.event_res = EV_RAN;
                    end
                end else begin
                    run_we          = 1'b1;
                    run_waddr       = r_run_head;
                    run_wdata.id    = r_rid;
                    run_wdata.cpu   = r_cpu;
                    run_wdata.aux   = r_slice;
                    n_out.event_res = EV_RAN;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_head   <= '0;
            r_run_count  <= '0;
            r_wait_head  <= '0;
            r_wait_count <= '0;
            r_time_slice <= SLICE_RESET;
            r_idx        <= '0;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run_head   <= n_run_head;
            r_run_count  <= n_run_count;
            r_wait_head  <= n_wait_head;
            r_wait_count <= n_wait_count;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            if (i_cfg_we) begin
                r_time_slice <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_hid   <= n_hid;
        r_hcpu  <= n_hcpu;
        r_hio   <= n_hio;
        r_woke  <= n_woke;
        r_wid   <= n_wid;
        r_rid   <= n_rid;
        r_cpu   <= n_cpu;
        r_slice <= n_slice;
        r_io    <= n_io;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;

endmodule

FILE: rtl/rrs_ram.sv
// ----------------------------------------------------------------------------
// rrs_ram: generic simple dual-port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
